/* src/scta_pkg.sv */
// Package with the types, scancode constants and character tables of the scancode decoder.
`timescale 1ns / 1ps

package scta_pkg;

  localparam int KEY_COUNT = 58;
  localparam int KEY_IDX_W = $clog2(KEY_COUNT);

  localparam int CODE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int EVENT_W = 2;
  localparam int MOD_W   = 3;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CODE_W-1:0] RELEASE_BASE = 8'd128;

  localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'd42;
  localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'd54;
  localparam logic [CODE_W-1:0] SC_LCTRL_MAKE   = 8'd29;
  localparam logic [CODE_W-1:0] SC_LALT_MAKE    = 8'd56;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'd170;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'd182;
  localparam logic [CODE_W-1:0] SC_LCTRL_BREAK  = 8'd157;
  localparam logic [CODE_W-1:0] SC_LALT_BREAK   = 8'd184;

  localparam int MOD_SHIFT = 0;
  localparam int MOD_CTRL  = 1;
  localparam int MOD_ALT   = 2;

  localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EVENT_W-1:0] EV_PRESSED  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASED = 2'd2;

  typedef struct packed {
    logic [MOD_W-1:0]   modifier_bits;
    logic [EVENT_W-1:0] key_event;
    logic [CHAR_W-1:0]  ascii_char;
  } result_t;

  localparam logic [CHAR_W-1:0] PLAIN_ROM [KEY_COUNT] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h5E, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h40, 7'h5B, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h3A, 7'h00, 7'h00, 7'h5D, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  localparam logic [CHAR_W-1:0] SHIFT_ROM [KEY_COUNT] = '{
    7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28,
    7'h29, 7'h00, 7'h3D, 7'h7E, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h60, 7'h7B, 7'h00, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h2B,
    7'h2A, 7'h00, 7'h00, 7'h7D, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

/* src/scancode_to_ascii_decoder_core.sv */
// Top level of the set-1 scancode to ASCII decoder with its stream interfaces.
`timescale 1ns / 1ps

// Decodes one set-1 scancode per transaction into a character, the last key event kind and
// the shift, ctrl and alt bits held after that code. The block takes a new transaction in
// every clock cycle while the master side is not stalled; a result is offered on the master
// side once its transaction has passed the input register and the result register. The
// modifier and event state is updated as a code moves from the input register through the
// table lookup into the result register, so codes are decoded strictly in arrival order.
// A stalled master side holds its result, and the slave side keeps accepting until both
// registers are full.

module scancode_to_ascii_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [scta_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] scan_code
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [scta_pkg::OUT_TDATA_W-1:0]    m_tdata    // [6:0] ascii_char, [8:7] key_event,
                                                         // [11:9] modifier_bits, [15:12] zero
);
  import scta_pkg::*;

  logic                in_valid;
  logic [CODE_W-1:0]   in_code;
  logic [MOD_W-1:0]    modifier_flags;
  logic [EVENT_W-1:0]  last_event_kind;
  result_t             lookup_res;
  result_t             out_res;
  logic                out_free;
  logic                advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  scta_lookup u_lookup (
    .code       (in_code),
    .flags      (modifier_flags),
    .last_event (last_event_kind),
    .res        (lookup_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_flags  <= '0;
      last_event_kind <= EV_NONE;
      m_tvalid        <= 1'b0;
    end else begin
      if (advance) begin
        modifier_flags  <= lookup_res.modifier_bits;
        last_event_kind <= lookup_res.key_event;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= lookup_res;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), out_res};

endmodule

/* src/scta_lookup.sv */
// Combinational decode of one scancode against the current modifier and event state.
`timescale 1ns / 1ps

module scta_lookup (
  input  logic [scta_pkg::CODE_W-1:0]  code,
  input  logic [scta_pkg::MOD_W-1:0]   flags,
  input  logic [scta_pkg::EVENT_W-1:0] last_event,
  output scta_pkg::result_t            res
);
  import scta_pkg::*;

  logic                 is_press;
  logic                 is_release;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [CHAR_W-1:0]    rom_char;

  // Releases differ from presses only in bit 7, so the low bits index both tables.
  assign is_press   = (code < CODE_W'(KEY_COUNT));
  assign is_release = (code >= RELEASE_BASE) && (code < RELEASE_BASE + CODE_W'(KEY_COUNT));
  assign key_idx    = code[KEY_IDX_W-1:0];
  assign rom_char   = flags[MOD_SHIFT] ? SHIFT_ROM[key_idx] : PLAIN_ROM[key_idx];

  always_comb begin
    res.ascii_char    = '0;
    res.key_event     = last_event;
    res.modifier_bits = flags;
    unique case (code) inside
      SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: begin
        res.modifier_bits[MOD_SHIFT] = 1'b1;
      end
      SC_LCTRL_MAKE: begin
        res.modifier_bits[MOD_CTRL] = 1'b1;
      end
      SC_LALT_MAKE: begin
        res.modifier_bits[MOD_ALT] = 1'b1;
      end
      SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: begin
        res.modifier_bits[MOD_SHIFT] = 1'b0;
      end
      SC_LCTRL_BREAK: begin
        res.modifier_bits[MOD_CTRL] = 1'b0;
      end
      SC_LALT_BREAK: begin
        res.modifier_bits[MOD_ALT] = 1'b0;
      end
      default: begin
        if (is_press) begin
          res.key_event  = EV_PRESSED;
          res.ascii_char = rom_char;
        end else if (is_release) begin
          res.key_event  = EV_RELEASED;
          res.ascii_char = rom_char;
        end
      end
    endcase
  end

endmodule

/* src/scta_checker.sv */
// Port-level assertions for the scancode decoder and their binding to the top level.
`timescale 1ns / 1ps

module scta_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [scta_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import scta_pkg::*;

  // No result may be offered in the cycle after a reset.
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  // A result that is not taken stays offered and unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or was dropped");

  // The event kind only ever takes one of its three meaningful values.
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[8:7] != 2'd3)
    else $error("undefined key event code");

  // A character can only come from a key event, so none appears before the first one.
  a_no_char_without_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8:7] == EV_NONE |-> m_tdata[6:0] == '0)
    else $error("character produced before any key event");

  // A full input register with room at the output must not refuse a new transaction.
  a_accepts_when_draining: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled although the output is draining");

endmodule

bind scancode_to_ascii_decoder_core scta_checker u_scta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/sv/tb_scancode_to_ascii_decoder_core.sv */
// Self-checking testbench for the set-1 scancode to ASCII decoder core.
`timescale 1ns / 1ps

module tb_scancode_to_ascii_decoder_core;
  import scta_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  scancode_to_ascii_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  logic [7:0] plain_keys [KEY_COUNT] = '{
    8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8",
    "9", "0", "-", "^", 8'h08, 8'h09, "q", "w", "e", "r",
    "t", "y", "u", "i", "o", "p", "@", "[", 8'h0A, 8'h00,
    "a", "s", "d", "f", "g", "h", "j", "k", "l", ";",
    ":", 8'h00, 8'h00, "]", "z", "x", "c", "v", "b", "n",
    "m", ",", ".", "/", 8'h00, 8'h00, 8'h00, " "
  };

  logic [7:0] shift_keys [KEY_COUNT] = '{
    8'h00, 8'h00, "!", "\"", "#", "$", "%", "&", "'", "(",
    ")", 8'h00, "=", "~", 8'h00, 8'h00, "Q", "W", "E", "R",
    "T", "Y", "U", "I", "O", "P", 8'h60, "{", 8'h00, 8'h00,
    "A", "S", "D", "F", "G", "H", "J", "K", "L", "+",
    "*", 8'h00, 8'h00, "}", "Z", "X", "C", "V", "B", "N",
    "M", "<", ">", "?", 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [MOD_W-1:0]   held_mods      = '0;
  logic [EVENT_W-1:0] recorded_event = EV_NONE;
  result_t            decoded_q [$];

  int tx_gap_max     = 5;
  int rx_stall_max   = 5;
  int rx_hold_cycles = 0;
  int codes_sent     = 0;
  int results_seen   = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int key_presses    = 0;
  int key_releases   = 0;
  int modifier_codes = 0;
  int stray_codes    = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t decode_scancode(input logic [CODE_W-1:0] code);
    result_t           r;
    logic [CODE_W-1:0] idx;
    logic              is_key;
    r      = '0;
    idx    = code;
    is_key = 1'b0;
    if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      held_mods[MOD_SHIFT] = 1'b1;
      modifier_codes++;
    end else if (code == SC_LCTRL_MAKE) begin
      held_mods[MOD_CTRL] = 1'b1;
      modifier_codes++;
    end else if (code == SC_LALT_MAKE) begin
      held_mods[MOD_ALT] = 1'b1;
      modifier_codes++;
    end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
      held_mods[MOD_SHIFT] = 1'b0;
      modifier_codes++;
    end else if (code == SC_LCTRL_BREAK) begin
      held_mods[MOD_CTRL] = 1'b0;
      modifier_codes++;
    end else if (code == SC_LALT_BREAK) begin
      held_mods[MOD_ALT] = 1'b0;
      modifier_codes++;
    end else if (code < KEY_COUNT) begin
      recorded_event = EV_PRESSED;
      is_key         = 1'b1;
      key_presses++;
    end else if (code >= RELEASE_BASE && code < RELEASE_BASE + KEY_COUNT) begin
      recorded_event = EV_RELEASED;
      idx            = code - RELEASE_BASE;
      is_key         = 1'b1;
      key_releases++;
    end else begin
      stray_codes++;
    end
    if (is_key) begin
      r.ascii_char = held_mods[MOD_SHIFT] ? shift_keys[idx][CHAR_W-1:0]
                                          : plain_keys[idx][CHAR_W-1:0];
    end
    r.key_event     = recorded_event;
    r.modifier_bits = held_mods;
    return r;
  endfunction

  task automatic send_code(input logic [CODE_W-1:0] code);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decoded_q.push_back(decode_scancode(code));
    codes_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A key stroke with a random set of modifiers held around it; the modifiers are
  // usually let go again, sometimes by the other shift key.
  task automatic type_sequence();
    logic [MOD_W-1:0]  mods;
    logic [CODE_W-1:0] key;
    logic [CODE_W-1:0] shift_make;
    logic [CODE_W-1:0] shift_break;
    mods        = MOD_W'($urandom);
    key         = CODE_W'($urandom_range(0, KEY_COUNT - 1));
    shift_make  = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
    shift_break = $urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK;
    if (mods[MOD_SHIFT]) send_code(shift_make);
    if (mods[MOD_CTRL]) send_code(SC_LCTRL_MAKE);
    if (mods[MOD_ALT]) send_code(SC_LALT_MAKE);
    send_code(key);
    if ($urandom_range(0, 3) == 0) send_code(key);
    send_code(key | RELEASE_BASE);
    if ($urandom_range(0, 4) != 0) begin
      if (mods[MOD_SHIFT]) send_code(shift_break);
      if (mods[MOD_CTRL]) send_code(SC_LCTRL_BREAK);
      if (mods[MOD_ALT]) send_code(SC_LALT_BREAK);
    end
  endtask

  task automatic type_until(input int total);
    while (codes_sent < total) begin
      if ($urandom_range(0, 4) == 0) send_code(CODE_W'($urandom_range(0, 255)));
      else type_sequence();
    end
  endtask

  task automatic test_codes_before_any_key();
    send_code(8'd58);
    send_code(8'd127);
    send_code(8'd186);
    send_code(8'd255);
  endtask

  task automatic test_key_range_edges();
    send_code(8'd0);
    send_code(8'd57);
    send_code(8'd128);
    send_code(8'd185);
    send_code(8'd1);
    send_code(8'd14);
    send_code(8'd28);
  endtask

  task automatic test_modifier_keys();
    send_code(SC_LSHIFT_MAKE);
    send_code(8'd30);
    send_code(8'd11);
    send_code(SC_LSHIFT_BREAK);
    send_code(SC_RSHIFT_MAKE);
    send_code(8'd158);
    send_code(SC_RSHIFT_BREAK);
    send_code(SC_LCTRL_MAKE);
    send_code(SC_LALT_MAKE);
    send_code(8'd16);
    send_code(SC_LCTRL_BREAK);
    send_code(SC_LALT_BREAK);
    wait_drained();
  endtask

  task automatic test_backpressure_fill();
    tx_gap_max     = 0;
    rx_hold_cycles = HOLD_CYCLES;
    type_until(codes_sent + 16);
    wait_drained();
    tx_gap_max = 5;
  endtask

  task automatic test_random_typing();
    tx_gap_max   = 5;
    rx_stall_max = 5;
    type_until(codes_sent + 300);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    type_until(codes_sent + 200);
    rx_stall_max = 5;
    type_until(codes_sent + 150);
    tx_gap_max = 5;
  endtask

  task automatic test_pause_and_resume();
    repeat (5) begin
      type_until(codes_sent + 20);
      wait_drained();
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      results_seen++;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, expected none, got %h",
                 $time, m_tdata);
      end else begin
        want = decoded_q.pop_front();
        if (got.ascii_char !== want.ascii_char) begin
          errors++;
          $display("%0t: ascii_char expected %h, got %h", $time, want.ascii_char,
                   got.ascii_char);
        end
        if (got.key_event !== want.key_event) begin
          errors++;
          $display("%0t: key_event expected %0d, got %0d", $time, want.key_event,
                   got.key_event);
        end
        if (got.modifier_bits !== want.modifier_bits) begin
          errors++;
          $display("%0t: modifier_bits expected %b, got %b", $time, want.modifier_bits,
                   got.modifier_bits);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, decoded_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_codes_before_any_key();
    test_key_range_edges();
    test_modifier_keys();
    test_backpressure_fill();
    test_random_typing();
    test_pause_and_resume();
    wait_drained();
    $display("Sent %0d scancodes: %0d key presses, %0d key releases, %0d modifier codes,",
             codes_sent, key_presses, key_releases, modifier_codes);
    $display("%0d codes outside the key ranges; %0d results checked, %0d mismatches.",
             stray_codes, results_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
